/* hw/rtl/lru_block_buffer_cache_macros.svh */
// Assertion macros used by the checker of the buffer cache block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef LRU_BLOCK_BUFFER_CACHE_MACROS_SVH
`define LRU_BLOCK_BUFFER_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define LBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buffer cache assertion failed");

// Next-cycle implication, disabled while reset is held
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buffer cache assertion failed");

`endif

/* hw/rtl/lbc_pkg.sv */
// Package of the buffer cache block: field widths, op and status codes,
// item structs and the stored entry layout. Depends on nothing.
`default_nettype none

package lbc_pkg;

    localparam int DEV_W       = 8;
    localparam int BLK_W       = 32;
    localparam int REFCNT_W    = 8;
    localparam int SLOT_W      = 5;
    localparam int ENTRY_W     = 5;
    localparam int BUFFERS_DEF = 32;

    localparam logic [REFCNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_DONE    = 2'd3
    } lbc_op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNREF  = 2'd2,
        ST_SAT    = 2'd3
    } lbc_status_t;

    typedef struct packed {
        lbc_op_t           op;
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block_number;
        logic [SLOT_W-1:0] slot;
    } lbc_in_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic               hit;
        logic               need_read;
        logic               need_write;
        lbc_status_t        status;
    } lbc_out_t;

    // Tag and policy fields of one entry, rank kept apart (width follows BUFFERS)
    typedef struct packed {
        logic [DEV_W-1:0]    device;
        logic [BLK_W-1:0]    block_number;
        logic [REFCNT_W-1:0] count;
        logic                valid;
        logic                dirty;
    } lbc_tag_t;

endpackage

`default_nettype wire

/* hw/rtl/lbc_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
)(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lru_block_buffer_cache.sv */
// Top level of the LRU buffer cache tag and policy store.
// Depends on lbc_pkg and lbc_ram.
//
//  channel   dir   handshake              payload
//  in        in    in_valid / in_ready    in_data  (lbc_in_t)
//  out       out   out_valid / out_ready  out_data (lbc_out_t)
//
// One item at a time. Read: S_SCAN reads every entry, one entry per cycle
// through the single RAM read port, then S_DECIDE, S_EMIT. Write, disk done and
// a release that leaves the count above zero: S_SLOT, S_EMIT. A release that
// frees the entry: S_SLOT, S_SWEEP over every entry, S_EMIT. Out of range slot: S_EMIT.
// Reset leaves every entry at its reset value at once (per-entry written
// bits); no clearing pass. A stalled result waits in the output register.
`default_nettype none

module lru_block_buffer_cache
    import lbc_pkg::*;
#(
    parameter int BUFFERS = BUFFERS_DEF
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire lbc_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output lbc_out_t     out_data
);

    localparam int IDX_W  = $clog2(BUFFERS);
    localparam int SCAN_W = $clog2(BUFFERS + 1);
    localparam int WORD_W = $bits(lbc_tag_t) + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFERS - 1);

    typedef struct packed {
        lbc_tag_t         tag;
        logic [IDX_W-1:0] rank;
    } word_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_SLOT   = 6'b001000,
        S_SWEEP  = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    function automatic logic [ENTRY_W-1:0] to_entry(input logic [IDX_W-1:0] idx);
        logic [IDX_W+ENTRY_W-1:0] wide;
        wide = {{ENTRY_W{1'b0}}, idx};
        return wide[ENTRY_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [SLOT_W-1:0] slot);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, slot};
        return wide[IDX_W-1:0];
    endfunction

    // control registers
    state_t              state_reg, state_next;
    logic [SCAN_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [BUFFERS-1:0]  written_reg;
    logic                hit_found_reg, hit_found_next;
    logic                free_found_reg, free_found_next;
    logic                out_valid_reg, out_valid_next;

    // payload registers
    lbc_in_t             req_reg, req_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    word_t               hit_word_reg, hit_word_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]    free_rank_reg, free_rank_next;
    logic [IDX_W-1:0]    tgt_rank_reg, tgt_rank_next;
    lbc_out_t            res_reg, res_next;
    lbc_out_t            out_data_reg, out_data_next;

    // RAM port signals
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    word_t               rd_word;
    word_t               wr_word;
    word_t               rst_word;
    logic [IDX_W-1:0]    slot_idx;
    logic [IDX_W-1:0]    in_slot_idx;
    logic                in_slot_ok;
    logic                tag_match;

    lbc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUFFERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign ram_wdata = wr_word;

    // entries never written read as their reset value
    always_comb
    begin
        rst_word.tag  = '0;
        rst_word.rank = LAST_IDX - rd_idx_reg;
        rd_word       = written_reg[rd_idx_reg] ? word_t'(ram_rdata) : rst_word;
    end

    assign slot_idx    = to_idx(req_reg.slot);
    assign in_slot_idx = to_idx(in_data.slot);
    assign in_slot_ok  = (32'(in_data.slot) < 32'(BUFFERS));
    assign tag_match   = (rd_word.tag.device == req_reg.device)
                      && (rd_word.tag.block_number == req_reg.block_number);

    // sequencer: scan, decide, read-modify-write, rank sweep
    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        out_valid_next  = out_valid_reg;
        req_next        = req_reg;
        hit_idx_next    = hit_idx_reg;
        hit_word_next   = hit_word_reg;
        free_idx_next   = free_idx_reg;
        free_rank_next  = free_rank_reg;
        tgt_rank_next   = tgt_rank_reg;
        res_next        = res_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        wr_word         = rd_word;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_data;
                    if (in_data.op == OP_READ)
                    begin
                        ram_re          = 1'b1;
                        ram_raddr       = '0;
                        scan_cnt_next   = SCAN_W'(1);
                        hit_found_next  = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    else if (!in_slot_ok)
                    begin
                        res_next.entry      = in_data.slot;
                        res_next.hit        = 1'b0;
                        res_next.need_read  = 1'b0;
                        res_next.need_write = 1'b0;
                        res_next.status     = ST_UNREF;
                        state_next          = S_EMIT;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = in_slot_idx;
                        state_next = S_SLOT;
                    end
                end
            end

            S_SCAN:
            begin
                // issue next read while the previous entry is examined
                if (scan_cnt_reg < SCAN_W'(BUFFERS))
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
                // most recent match
                if (tag_match && (!hit_found_reg || rd_word.rank < hit_word_reg.rank))
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = rd_idx_reg;
                    hit_word_next  = rd_word;
                end
                // least recent free, clean entry
                if (rd_word.tag.count == '0 && !rd_word.tag.dirty
                    && (!free_found_reg || rd_word.rank > free_rank_reg))
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                    free_rank_next  = rd_word.rank;
                end
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                res_next.hit        = 1'b0;
                res_next.need_read  = 1'b0;
                res_next.need_write = 1'b0;
                res_next.status     = ST_OK;
                if (hit_found_reg)
                begin
                    res_next.entry     = to_entry(hit_idx_reg);
                    res_next.hit       = 1'b1;
                    res_next.need_read = !hit_word_reg.tag.valid;
                    if (hit_word_reg.tag.count == COUNT_MAX)
                    begin
                        res_next.status = ST_SAT;
                    end
                    else
                    begin
                        wr_word           = hit_word_reg;
                        wr_word.tag.count = hit_word_reg.tag.count + REFCNT_W'(1);
                        ram_we            = 1'b1;
                        ram_waddr         = hit_idx_reg;
                    end
                end
                else if (free_found_reg)
                begin
                    wr_word.tag.device       = req_reg.device;
                    wr_word.tag.block_number = req_reg.block_number;
                    wr_word.tag.count        = REFCNT_W'(1);
                    wr_word.tag.valid        = 1'b0;
                    wr_word.tag.dirty        = 1'b0;
                    wr_word.rank             = free_rank_reg;
                    ram_we                   = 1'b1;
                    ram_waddr                = free_idx_reg;
                    res_next.entry           = to_entry(free_idx_reg);
                    res_next.need_read       = 1'b1;
                end
                else
                begin
                    res_next.entry  = '0;
                    res_next.status = ST_NOFREE;
                end
                state_next = S_EMIT;
            end

            S_SLOT:
            begin
                res_next.entry      = req_reg.slot;
                res_next.hit        = 1'b0;
                res_next.need_read  = 1'b0;
                res_next.need_write = 1'b0;
                res_next.status     = ST_OK;
                ram_waddr           = slot_idx;
                state_next          = S_EMIT;
                if (req_reg.op == OP_DONE)
                begin
                    wr_word.tag.valid = 1'b1;
                    wr_word.tag.dirty = 1'b0;
                    ram_we            = 1'b1;
                end
                else if (rd_word.tag.count == '0)
                begin
                    res_next.status = ST_UNREF;
                end
                else if (req_reg.op == OP_WRITE)
                begin
                    wr_word.tag.dirty   = 1'b1;
                    ram_we              = 1'b1;
                    res_next.need_write = 1'b1;
                end
                else if (rd_word.tag.count == REFCNT_W'(1))
                begin
                    // last reference gone: move to most recent over a sweep
                    tgt_rank_next = rd_word.rank;
                    ram_re        = 1'b1;
                    ram_raddr     = '0;
                    state_next    = S_SWEEP;
                end
                else
                begin
                    wr_word.tag.count = rd_word.tag.count - REFCNT_W'(1);
                    ram_we            = 1'b1;
                end
            end

            S_SWEEP:
            begin
                if (rd_idx_reg != LAST_IDX)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rd_idx_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = S_EMIT;
                end
                // age everything newer than the released entry
                if (rd_idx_reg == slot_idx)
                begin
                    wr_word.tag.count = '0;
                    wr_word.rank      = '0;
                end
                else if (rd_word.rank < tgt_rank_reg)
                begin
                    wr_word.rank = rd_word.rank + IDX_W'(1);
                end
                ram_we    = 1'b1;
                ram_waddr = rd_idx_reg;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_cnt_reg   <= '0;
            written_reg    <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
            if (ram_we)
            begin
                written_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        hit_idx_reg   <= hit_idx_next;
        hit_word_reg  <= hit_word_next;
        free_idx_reg  <= free_idx_next;
        free_rank_reg <= free_rank_next;
        tgt_rank_reg  <= tgt_rank_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
        if (ram_re)
        begin
            rd_idx_reg <= ram_raddr;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lbc_checker.sv */
// Port-level checker of the buffer cache block, bound to the top level.
// Depends on lbc_pkg and lru_block_buffer_cache_macros.svh.
`default_nettype none

`include "lru_block_buffer_cache_macros.svh"

module lbc_checker
    import lbc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_ready,
    input  wire logic     out_valid,
    input  wire logic     out_ready,
    input  wire lbc_out_t out_data
);

    // a stalled result holds
    `LBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // one item in flight: no accept right after an accept
    `LBC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

    // no free buffer reports entry 0 and no flags
    `LBC_ASSERT_IMPLY(a_nofree_form, clk, rst_n, out_valid && out_data.status == ST_NOFREE, out_data.entry == '0 && !out_data.hit && !out_data.need_read && !out_data.need_write)

    // a hit is ok or saturated and never asks for a disk write
    `LBC_ASSERT_IMPLY(a_hit_form, clk, rst_n, out_valid && out_data.hit, (out_data.status == ST_OK || out_data.status == ST_SAT) && !out_data.need_write)

    // a disk write request comes only from an accepted write
    `LBC_ASSERT_IMPLY(a_write_form, clk, rst_n, out_valid && out_data.need_write, out_data.status == ST_OK && !out_data.hit && !out_data.need_read)

endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

/* sim/lru_block_buffer_cache_test.sv */
// Self-checking testbench of the LRU buffer cache tag and policy store.
// Depends on lbc_pkg and the lru_block_buffer_cache RTL; keeps a shadow copy of
// every entry, predicts each result and checks it against the output channel.
`default_nettype none

module lru_block_buffer_cache_test;
    import lbc_pkg::*;

    localparam int N_BUF          = BUFFERS_DEF;
    localparam int RANK_W         = $clog2(N_BUF);
    localparam int POOL_SIZE      = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = N_BUF + 16;
    localparam int STALL_CYCLES   = 400;
    localparam int RANDOM_ITEMS   = 65;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    lbc_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    lbc_out_t out_data;

    // Shadow copy of the cache entries
    logic [DEV_W-1:0]    sh_dev   [N_BUF];
    logic [BLK_W-1:0]    sh_blk   [N_BUF];
    logic [REFCNT_W-1:0] sh_count [N_BUF];
    logic                sh_valid [N_BUF];
    logic                sh_dirty [N_BUF];
    logic [RANK_W-1:0]   sh_rank  [N_BUF];

    // Keys that random reads draw from, so that hits and evictions both happen
    logic [DEV_W-1:0] pool_dev [POOL_SIZE];
    logic [BLK_W-1:0] pool_blk [POOL_SIZE];

    lbc_out_t pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int err_count     = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_hit         = 0;
    int n_granted     = 0;
    int n_nofree      = 0;
    int n_sat         = 0;
    int n_unref       = 0;

    lru_block_buffer_cache #(.BUFFERS(N_BUF)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Shadow state after reset
    task automatic reset_shadow();
        int i;
        for (i = 0; i < N_BUF; i++)
        begin
            sh_dev[i]   = '0;
            sh_blk[i]   = '0;
            sh_count[i] = '0;
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_rank[i]  = RANK_W'(N_BUF - 1 - i);
        end
    endtask

    // Move an entry to most recently used, ageing the ones ahead of it
    function automatic void promote_entry(int e);
        logic [RANK_W-1:0] old_rank;
        int i;
        old_rank = sh_rank[e];
        for (i = 0; i < N_BUF; i++)
            if (sh_rank[i] < old_rank)
                sh_rank[i] = sh_rank[i] + 1'b1;
        sh_rank[e] = '0;
    endfunction

    // Expected result of one request; updates the shadow state
    function automatic lbc_out_t cache_response(lbc_in_t req);
        lbc_out_t res;
        int i;
        int sel;
        bit found;
        res        = '0;
        res.entry  = req.slot;
        res.status = ST_OK;
        sel        = 0;
        found      = 1'b0;
        if (req.op == OP_READ)
        begin
            // lookup, most recently used match wins
            for (i = 0; i < N_BUF; i++)
                if (sh_dev[i] == req.device && sh_blk[i] == req.block_number &&
                    (!found || sh_rank[i] < sh_rank[sel]))
                begin
                    sel   = i;
                    found = 1'b1;
                end
            if (found)
            begin
                res.entry     = ENTRY_W'(sel);
                res.hit       = 1'b1;
                res.need_read = !sh_valid[sel];
                if (sh_count[sel] == COUNT_MAX)
                    res.status = ST_SAT;
                else
                    sh_count[sel] = sh_count[sel] + 1'b1;
                return res;
            end
            // victim: least recently used, unreferenced and clean
            for (i = 0; i < N_BUF; i++)
                if (sh_count[i] == 0 && !sh_dirty[i] && (!found || sh_rank[i] > sh_rank[sel]))
                begin
                    sel   = i;
                    found = 1'b1;
                end
            if (!found)
            begin
                res.entry  = '0;
                res.status = ST_NOFREE;
                return res;
            end
            sh_dev[sel]   = req.device;
            sh_blk[sel]   = req.block_number;
            sh_valid[sel] = 1'b0;
            sh_dirty[sel] = 1'b0;
            sh_count[sel] = REFCNT_W'(1);
            res.entry     = ENTRY_W'(sel);
            res.need_read = 1'b1;
            return res;
        end
        if (int'(req.slot) >= N_BUF)
        begin
            res.status = ST_UNREF;
            return res;
        end
        if (req.op == OP_DONE)
        begin
            sh_valid[req.slot] = 1'b1;
            sh_dirty[req.slot] = 1'b0;
            return res;
        end
        if (sh_count[req.slot] == 0)
        begin
            res.status = ST_UNREF;
            return res;
        end
        if (req.op == OP_WRITE)
        begin
            sh_dirty[req.slot] = 1'b1;
            res.need_write     = 1'b1;
            return res;
        end
        sh_count[req.slot] = sh_count[req.slot] - 1'b1;
        if (sh_count[req.slot] == 0)
            promote_entry(req.slot);
        return res;
    endfunction

    function automatic lbc_in_t make_req(lbc_op_t op, logic [DEV_W-1:0] dev,
                                         logic [BLK_W-1:0] blk, int slot);
        lbc_in_t req;
        req.op           = op;
        req.device       = dev;
        req.block_number = blk;
        req.slot         = SLOT_W'(slot);
        return req;
    endfunction

    // Request on an entry; the tag fields carry random noise
    function automatic lbc_in_t slot_req(lbc_op_t op, int slot);
        return make_req(op, DEV_W'($urandom), $urandom, slot);
    endfunction

    function automatic int free_entries();
        int i;
        int n;
        n = 0;
        for (i = 0; i < N_BUF; i++)
            if (sh_count[i] == 0 && !sh_dirty[i])
                n++;
        return n;
    endfunction

    // Random entry in use, or one waiting for its disk transfer
    function automatic int pick_slot(bit want_done);
        int cand[$];
        int i;
        for (i = 0; i < N_BUF; i++)
            if (want_done ? (sh_dirty[i] || (sh_count[i] != 0 && !sh_valid[i]))
                          : (sh_count[i] != 0))
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    // Mostly reads of pooled keys and follow-ups on live entries; the rest is noise
    function automatic lbc_in_t random_request(int read_pct);
        lbc_in_t req;
        int r;
        int kind;
        int s;
        int k;
        req.op           = lbc_op_t'($urandom_range(3));
        req.device       = DEV_W'($urandom);
        req.block_number = $urandom;
        req.slot         = SLOT_W'($urandom);
        r = $urandom_range(99);
        if (r < read_pct)
        begin
            req.op = OP_READ;
            if ($urandom_range(19) != 0)
            begin
                k                = $urandom_range(POOL_SIZE - 1);
                req.device       = pool_dev[k];
                req.block_number = pool_blk[k];
            end
        end
        else if (r < 95)
        begin
            kind = $urandom_range(5);
            s    = pick_slot(kind >= 4);
            if (s < 0)
                s = pick_slot(1'b0);
            if (s >= 0)
            begin
                req.slot = SLOT_W'(s);
                if (kind <= 2)
                    req.op = OP_RELEASE;
                else if (kind == 3)
                    req.op = OP_WRITE;
                else
                    req.op = OP_DONE;
            end
        end
        return req;
    endfunction

    // Offer one item, with random idle cycles first; predict on acceptance
    task automatic send_item(lbc_in_t req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pending_results.push_back(cache_response(req));
        n_sent++;
    endtask

    // Sender pause: stop offering until every expected result has come
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Drop every reference and flush dirty entries so that all are free again
    task automatic release_all();
        int i;
        for (i = 0; i < N_BUF; i++)
        begin
            while (sh_count[i] != 0)
                send_item(slot_req(OP_RELEASE, i));
            if (sh_dirty[i])
                send_item(slot_req(OP_DONE, i));
        end
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Field extremes, every op and the corner cases of lookup and release
    task automatic test_directed_cases();
        send_item(make_req(OP_READ, '0, '0, 0));          // reset tags match: hit on MRU
        send_item(make_req(OP_READ, '1, '1, 31));         // miss, LRU entry recycled
        send_item(slot_req(OP_WRITE, 0));
        send_item(make_req(OP_READ, '1, '1, 0));          // hit, dirty but still invalid
        send_item(slot_req(OP_DONE, 0));
        send_item(make_req(OP_READ, '1, '1, 0));          // hit, data valid
        send_item(slot_req(OP_RELEASE, 0));
        send_item(slot_req(OP_RELEASE, 0));
        send_item(slot_req(OP_RELEASE, 0));               // count to zero, becomes MRU
        send_item(slot_req(OP_RELEASE, 0));               // unreferenced release
        send_item(slot_req(OP_WRITE, 0));                 // unreferenced write
        send_item(slot_req(OP_DONE, 7));                  // disk done on idle entry
        send_item(slot_req(OP_RELEASE, 31));
        send_item(make_req(OP_READ, '0, '0, 0));          // many matches, MRU taken
        send_item(slot_req(OP_WRITE, 31));
        send_item(slot_req(OP_RELEASE, 31));              // dirty and unreferenced
        send_item(make_req(OP_READ, '0, '1, 0));          // device matches, block not
        send_item(make_req(OP_READ, '1, '0, 0));          // block matches, device not
        send_item(slot_req(OP_DONE, 31));
        send_item(slot_req(OP_RELEASE, 30));
        wait_drained();
    endtask

    // Reference every entry, then ask for more
    task automatic test_no_free_buffer();
        int guard;
        guard = 0;
        while (free_entries() > 0 && guard < 4 * N_BUF)
        begin
            send_item(make_req(OP_READ, DEV_W'($urandom), $urandom, 0));
            guard++;
        end
        send_item(make_req(OP_READ, DEV_W'($urandom), $urandom, 0));
        send_item(make_req(OP_READ, DEV_W'($urandom), $urandom, 0));
        send_item(make_req(OP_READ, '1, '1, 0));          // miss when full: no free buffer
        release_all();
        wait_drained();
    endtask

    // Long receiver stall while items keep coming, so the input backs up
    task automatic test_output_stall();
        int i;
        @(posedge clk);
        hold_left = STALL_CYCLES;
        for (i = 0; i < 12; i++)
            send_item(random_request(50));
        wait_drained();
    endtask

    task automatic test_random_traffic(int n_items, int read_pct);
        int i;
        for (i = 0; i < n_items; i++)
            send_item(random_request(read_pct));
        wait_drained();
    endtask

    // Drive one entry's count to its ceiling and past it
    task automatic test_count_saturation();
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        int i;
        int e;
        dev = 8'hA5;
        blk = 32'h5A5A_F00D;
        e   = -1;
        release_all();
        for (i = 0; i < int'(COUNT_MAX) + 2; i++)
            send_item(make_req(OP_READ, dev, blk, 0));
        for (i = 0; i < N_BUF; i++)
            if (sh_dev[i] == dev && sh_blk[i] == blk && sh_count[i] != 0)
                e = i;
        if (e >= 0)
        begin
            send_item(slot_req(OP_RELEASE, e));
            send_item(slot_req(OP_DONE, e));
            send_item(make_req(OP_READ, dev, blk, 0));
            send_item(make_req(OP_READ, dev, blk, 0));    // back at the ceiling
        end
        wait_drained();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is asked for
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        lbc_out_t want;
        lbc_out_t got;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            got = out_data;
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: entry %0d status %0d",
                       got.entry, got.status);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.entry !== want.entry)
                begin
                    $error("entry: expected %0d, got %0d", want.entry, got.entry);
                    err_count++;
                end
                if (got.hit !== want.hit)
                begin
                    $error("hit: expected %0b, got %0b", want.hit, got.hit);
                    err_count++;
                end
                if (got.need_read !== want.need_read)
                begin
                    $error("need_read: expected %0b, got %0b", want.need_read, got.need_read);
                    err_count++;
                end
                if (got.need_write !== want.need_write)
                begin
                    $error("need_write: expected %0b, got %0b", want.need_write,
                           got.need_write);
                    err_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    err_count++;
                end
                // tally what the run has reached
                case (want.status)
                    ST_NOFREE: n_nofree++;
                    ST_UNREF:  n_unref++;
                    ST_SAT:    n_sat++;
                    default:
                    begin
                        if (want.hit)
                            n_hit++;
                        else if (want.need_read)
                            n_granted++;
                    end
                endcase
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        reset_shadow();
        pool_dev[0] = '0;
        pool_blk[0] = '0;
        pool_dev[1] = '1;
        pool_blk[1] = '1;
        for (k = 2; k < POOL_SIZE; k++)
        begin
            pool_dev[k] = DEV_W'($urandom);
            pool_blk[k] = $urandom;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(30, 82);
        test_directed_cases();
        test_no_free_buffer();
        test_output_stall();
        test_random_traffic(RANDOM_ITEMS, 35);
        set_idling(82, 30);
        test_random_traffic(RANDOM_ITEMS, 45);
        set_idling(0, 0);
        test_random_traffic(RANDOM_ITEMS, 30);
        test_count_saturation();

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
        end
        $display("Run: %0d items sent, %0d results checked over three idling phases",
                 n_sent, n_checked);
        $display("Reached: %0d hits, %0d fills, %0d no-free, %0d saturated, %0d unreferenced",
                 n_hit, n_granted, n_nofree, n_sat, n_unref);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
